// ----- sv/jktm_pkg.sv -----
package jktm_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int MAX_KEY_LEN = 32;

  localparam int CHAR_W = 8;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 5;
  localparam int ROW_W  = NUM_KEYS * CHAR_W;

  localparam logic [1:0] MODE_LOAD_CHAR = 2'd0;
  localparam logic [1:0] MODE_LOAD_LEN  = 2'd1;
  localparam logic [1:0] MODE_STREAM    = 2'd2;
  localparam logic [1:0] MODE_END       = 2'd3;

  localparam logic [CHAR_W-1:0] QUOTE_CHAR     = 8'h22;
  localparam logic [CHAR_W-1:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [CHAR_W-1:0] NUL_CHAR       = 8'h00;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_KEY_LEN);
  localparam logic [LEN_W-1:0] SEEN_MAX = LEN_W'(MAX_KEY_LEN + 1);

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] key_slot;
    logic [POS_W-1:0]  char_pos;
    logic [CHAR_W-1:0] char_value;
    logic [LEN_W-1:0]  key_length;
  } jktm_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] key_index;
  } jktm_out_t;

  // one processed item handed to the match unit
  typedef struct packed {
    logic     fire;
    jktm_in_t item;
  } jktm_step_t;

  // result of one processed item
  typedef struct packed {
    logic      valid;
    jktm_out_t data;
  } jktm_rep_t;

  // byte write into the key character memory
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  row;
    logic [SLOT_W-1:0] lane;
    logic [CHAR_W-1:0] data;
  } jktm_wr_t;

endpackage

// ----- sv/json_key_table_matcher_core.sv -----
// Channel  Direction  Payload     Handshake
// in_      input      jktm_in_t   in_valid / in_stall
// out_     output     jktm_out_t  out_valid / out_stall
// cfg_     input      key_count   cfg_we / cfg_wdata
//
// One item per cycle unless out_stall holds a waiting result; an item is held
// in the input register and its result, if any, in the result register; all keys
// are compared at once against one row of the character memory.
// Reset (rst_n, synchronous) empties both registers and clears the match state.
// in_stall rises only while the input register and a waiting result both hold.
module json_key_table_matcher_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  jktm_pkg::jktm_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output jktm_pkg::jktm_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [jktm_pkg::CNT_W-1:0]  cfg_wdata
);
  import jktm_pkg::*;

  logic             in_vld_r, in_vld_nxt;
  jktm_in_t         in_r;
  logic             out_vld_r, out_vld_nxt;
  jktm_out_t        out_r;
  logic [CNT_W-1:0] key_count_r;

  logic             adv;
  logic             in_xfer;
  jktm_step_t       step;
  jktm_rep_t        rep;
  jktm_wr_t         wr;
  logic [POS_W-1:0] rd_addr;
  logic [ROW_W-1:0] rd_data;

  // advance the held item once the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign step.fire = adv;
  assign step.item = in_r;

  // character loads go straight into the memory lane of their key
  assign wr.en   = adv && (in_r.mode == MODE_LOAD_CHAR);
  assign wr.row  = in_r.char_pos;
  assign wr.lane = in_r.key_slot;
  assign wr.data = in_r.char_value;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  // load a new result, drop the old one on transfer, otherwise hold
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (rep.valid) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      key_count_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
    if (rep.valid) begin
      out_r <= rep.data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  jktm_char_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  jktm_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .key_count (key_count_r),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .rep       (rep)
  );

endmodule

// ----- sv/jktm_char_ram.sv -----
module jktm_char_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jktm_pkg::jktm_wr_t            wr,
  input  logic [jktm_pkg::POS_W-1:0]    rd_addr,
  output logic [jktm_pkg::ROW_W-1:0]    rd_data
);
  import jktm_pkg::*;

  // one row per character position, one byte lane per key
  logic [ROW_W-1:0]  mem [MAX_KEY_LEN];
  logic [ROW_W-1:0]  rd_q_r;
  logic              byp_hit_r;
  logic [SLOT_W-1:0] byp_lane_r;
  logic [CHAR_W-1:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row][wr.lane*CHAR_W +: CHAR_W] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // forward a write that lands on the row being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= wr.en && (wr.row == rd_addr);
    end
    byp_lane_r <= wr.lane;
    byp_data_r <= wr.data;
  end

  always_comb begin
    rd_data = rd_q_r;
    if (byp_hit_r) begin
      rd_data[byp_lane_r*CHAR_W +: CHAR_W] = byp_data_r;
    end
  end

endmodule

// ----- sv/jktm_match.sv -----
module jktm_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jktm_pkg::jktm_step_t          step,
  input  logic [jktm_pkg::CNT_W-1:0]    key_count,
  input  logic [jktm_pkg::ROW_W-1:0]    rd_data,
  output logic [jktm_pkg::POS_W-1:0]    rd_addr,
  output jktm_pkg::jktm_rep_t           rep
);
  import jktm_pkg::*;

  logic [LEN_W-1:0]    key_len_r [NUM_KEYS];
  logic [NUM_KEYS-1:0] cand_r, cand_nxt;
  logic [LEN_W-1:0]    seen_r, seen_nxt;
  logic                bs_odd_r, bs_odd_nxt;

  logic [CNT_W-1:0]    active_n;
  logic [NUM_KEYS-1:0] active;
  logic [NUM_KEYS-1:0] hit;
  logic [NUM_KEYS-1:0] differ;
  logic                is_stream;
  logic                is_report;
  logic [CHAR_W-1:0]   ch;

  assign ch        = step.item.char_value;
  assign is_stream = step.item.mode == MODE_STREAM;
  assign is_report = (step.item.mode == MODE_END) ||
                     (is_stream && (ch == QUOTE_CHAR) && !bs_odd_r);
  assign active_n  = (key_count > CNT_W'(NUM_KEYS)) ? CNT_W'(NUM_KEYS) : key_count;

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      active[i] = CNT_W'(i) < active_n;
      hit[i]    = active[i] && cand_r[i] && (key_len_r[i] == seen_r);
      differ[i] = ((seen_r < key_len_r[i]) ? rd_data[i*CHAR_W +: CHAR_W] : NUL_CHAR) != ch;
    end
  end

  // lowest surviving key of matching length
  always_comb begin
    rep.valid          = step.fire && is_report;
    rep.data.found     = 1'b0;
    rep.data.key_index = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        rep.data.found     = 1'b1;
        rep.data.key_index = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cand_nxt   = cand_r;
    seen_nxt   = seen_r;
    bs_odd_nxt = bs_odd_r;
    if (step.fire && is_report) begin
      cand_nxt   = '1;
      seen_nxt   = '0;
      bs_odd_nxt = 1'b0;
    end else if (step.fire && is_stream) begin
      bs_odd_nxt = (ch == BACKSLASH_CHAR) ? !bs_odd_r : 1'b0;
      cand_nxt   = cand_r & ~(active & differ);
      if (seen_r != SEEN_MAX) begin
        seen_nxt = seen_r + LEN_W'(1);
      end
    end
  end

  // prefetch the row for the next character position
  assign rd_addr = rst_n ? seen_nxt[POS_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r   <= '1;
      seen_r   <= '0;
      bs_odd_r <= 1'b0;
    end else begin
      cand_r   <= cand_nxt;
      seen_r   <= seen_nxt;
      bs_odd_r <= bs_odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && (step.item.mode == MODE_LOAD_LEN)) begin
      key_len_r[step.item.key_slot] <= (step.item.key_length > LEN_MAX) ?
                                       LEN_MAX : step.item.key_length;
    end
  end

endmodule

// ----- sv/jktm_checker.sv -----
module jktm_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  jktm_pkg::jktm_out_t         out_data
);
  import jktm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a miss always reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.key_index == '0)
    else $error("miss with nonzero key_index");

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // stall needs an item held from an earlier transfer
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
    else $error("input stalled with no item held");

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind json_key_table_matcher_core jktm_checker u_chk (.*);

// ----- bench/testbench.sv -----
module testbench;
  import jktm_pkg::*;

  // Far above the slowest correct run: every transfer in can wait out a
  // send gap and a long receive stall, plus the idle pauses between settings.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 950;

  // Shapes of a streamed key built from a stored table entry.
  typedef enum int {
    KEY_EXACT,   // the stored text, then a closing quote
    KEY_FLIP,    // one bit of one character flipped
    KEY_SHORT,   // cut off early, then closed
    KEY_LONG,    // extra characters past the stored text
    KEY_EOT,     // closed by an end-of-text item
    KEY_MIXED,   // table loads slipped in between characters
    KEY_OPEN     // left unterminated, the next key continues it
  } key_shape_t;

  // Patterns of the result side stall.
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_SQUARE} rx_pattern_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  jktm_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  jktm_out_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Match predictor state, advanced once per transfer in.
  logic [CHAR_W-1:0]   tbl_char [NUM_KEYS][MAX_KEY_LEN];
  logic [LEN_W-1:0]    tbl_len  [NUM_KEYS];
  logic [NUM_KEYS-1:0] live_mask;
  logic [LEN_W-1:0]    seen_cnt;
  logic                bs_odd;
  logic [CNT_W-1:0]    tbl_count;

  // Match reports still owed by the block, oldest first.
  jktm_out_t match_q [$];

  // Items waiting for the driver, and the generator's view of the table
  // at the point where the queue currently ends.
  jktm_in_t    item_q [$];
  logic [7:0]  plan_char [NUM_KEYS][MAX_KEY_LEN];
  logic [31:0] plan_wr   [NUM_KEYS];
  int          plan_len  [NUM_KEYS];
  int          plan_count = 0;
  logic [7:0]  kbuf [MAX_KEY_LEN];

  int items_made    = 0;
  int items_taken   = 0;
  int reports       = 0;
  int hits          = 0;
  int errors        = 0;
  int cycles        = 0;
  int settings_used = 0;

  // Driver and receiver pacing.
  logic        in_took    = 1'b0;
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  rx_pattern_t stall_kind = RX_OPEN;

  json_key_table_matcher_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Close the current key: pick the lowest live entry whose length equals
  // the character count, then drop all match state.
  task automatic settle_key(output jktm_out_t rep);
    int n;
    n = (tbl_count > NUM_KEYS) ? NUM_KEYS : int'(tbl_count);
    rep = '0;
    for (int i = 0; i < n; i++) begin
      if (!rep.found && live_mask[i] && tbl_len[i] == seen_cnt) begin
        rep.found = 1'b1;
        rep.key_index = SLOT_W'(i);
      end
    end
    live_mask = '1;
    seen_cnt = '0;
    bs_odd = 1'b0;
  endtask

  task automatic step_matcher(input jktm_in_t it, output bit has_rep,
                              output jktm_out_t rep);
    int n;
    logic [CHAR_W-1:0] stored;
    has_rep = 1'b0;
    rep = '0;
    n = (tbl_count > NUM_KEYS) ? NUM_KEYS : int'(tbl_count);
    case (it.mode)
      MODE_LOAD_CHAR: tbl_char[it.key_slot][it.char_pos] = it.char_value;
      MODE_LOAD_LEN: tbl_len[it.key_slot] = (it.key_length > LEN_MAX) ? LEN_MAX : it.key_length;
      MODE_END: begin
        has_rep = 1'b1;
        settle_key(rep);
      end
      MODE_STREAM: begin
        if (it.char_value == QUOTE_CHAR && !bs_odd) begin
          has_rep = 1'b1;
          settle_key(rep);
        end else begin
          bs_odd = (it.char_value == BACKSLASH_CHAR) ? !bs_odd : 1'b0;
          for (int i = 0; i < n; i++) begin
            // past the stored length every entry reads as a zero byte
            stored = (seen_cnt < tbl_len[i] && seen_cnt < MAX_KEY_LEN) ?
                     tbl_char[i][seen_cnt[POS_W-1:0]] : NUL_CHAR;
            if (stored != it.char_value) live_mask[i] = 1'b0;
          end
          if (seen_cnt < SEEN_MAX) seen_cnt = seen_cnt + 1'b1;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------

  // Queue one item and track what it does to the table, so that later
  // length loads never expose characters that were never written.
  task automatic push_item(input logic [1:0] m, input int slot, input int pos,
                           input int ch, input int len);
    jktm_in_t it;
    it.mode       = m;
    it.key_slot   = SLOT_W'(slot);
    it.char_pos   = POS_W'(pos);
    it.char_value = CHAR_W'(ch);
    it.key_length = LEN_W'(len);
    if (m == MODE_LOAD_CHAR) begin
      plan_char[slot][pos] = it.char_value;
      plan_wr[slot][pos] = 1'b1;
    end
    if (m == MODE_LOAD_LEN) plan_len[slot] = (len > MAX_KEY_LEN) ? MAX_KEY_LEN : len;
    item_q.push_back(it);
    items_made++;
  endtask

  // Stream and end items carry random values in the fields they ignore.
  task automatic push_stream(input int ch);
    push_item(MODE_STREAM, $urandom_range(0, NUM_KEYS - 1), $urandom_range(0, 31), ch,
              $urandom_range(0, 63));
  endtask

  task automatic push_end();
    push_item(MODE_END, $urandom_range(0, NUM_KEYS - 1), $urandom_range(0, 31),
              $urandom_range(0, 255), $urandom_range(0, 63));
  endtask

  // Write kbuf[0..len-1] into a slot, characters first, then the length.
  task automatic put_key(input int slot, input int len, input int len_field);
    for (int p = 0; p < len; p++)
      push_item(MODE_LOAD_CHAR, slot, p, kbuf[p], $urandom_range(0, 63));
    push_item(MODE_LOAD_LEN, slot, $urandom_range(0, 31), $urandom_range(0, 255), len_field);
  endtask

  task automatic set_text(input string s);
    for (int p = 0; p < s.len(); p++) kbuf[p] = s[p];
  endtask

  // Mostly short keys over a tiny alphabet so that entries share prefixes,
  // with escaped quotes, escaped backslashes and the odd arbitrary byte.
  task automatic load_random_key(input int slot);
    int len;
    int p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) len = 0;
    else if (pick < 80) len = $urandom_range(1, 6);
    else if (pick < 95) len = $urandom_range(7, 31);
    else len = MAX_KEY_LEN;
    p = 0;
    while (p < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 && p + 1 < len) begin
        kbuf[p] = BACKSLASH_CHAR;
        kbuf[p + 1] = $urandom_range(0, 1) ? QUOTE_CHAR : BACKSLASH_CHAR;
        p += 2;
      end else begin
        kbuf[p] = (pick < 15) ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 3));
        p++;
      end
    end
    // a full-length key sometimes goes in with an oversized length field
    put_key(slot, len,
            (len == MAX_KEY_LEN && $urandom_range(0, 1)) ? $urandom_range(33, 63) : len);
  endtask

  // Duplicate entries exercise the lowest-index rule.
  task automatic copy_key(input int dst, input int src);
    int len;
    len = plan_len[src];
    for (int p = 0; p < len; p++) kbuf[p] = plan_char[src][p];
    put_key(dst, len, len);
  endtask

  task automatic stream_key(input int slot, input key_shape_t shape);
    int len;
    int stop;
    int flip_at;
    logic odd;
    logic [7:0] c;
    len = plan_len[slot];
    stop = (shape == KEY_SHORT || shape == KEY_OPEN) ? $urandom_range(0, len) : len;
    flip_at = $urandom_range(0, (len > 0) ? len - 1 : 0);
    odd = 1'b0;
    for (int p = 0; p < stop; p++) begin
      if (shape == KEY_MIXED && $urandom_range(0, 2) == 0)
        push_item(MODE_LOAD_CHAR, $urandom_range(0, NUM_KEYS - 1), $urandom_range(0, 31),
                  $urandom_range(0, 255), $urandom_range(0, 63));
      c = plan_char[slot][p];
      if (shape == KEY_FLIP && p == flip_at) c = c ^ (8'h1 << $urandom_range(0, 7));
      push_stream(c);
      odd = (c == BACKSLASH_CHAR) ? !odd : 1'b0;
    end
    if (shape == KEY_LONG) begin
      repeat ($urandom_range(1, 3)) push_stream($urandom_range(0, 1) ? NUL_CHAR : 8'h61);
      odd = 1'b0;
    end
    // a quote after an odd backslash run would not close, so end the text
    if (shape != KEY_OPEN) begin
      if (shape == KEY_EOT || odd) push_end();
      else push_stream(QUOTE_CHAR);
    end
  endtask

  // One random phase: mostly keys streamed from the table, plus reloads,
  // duplicates, garbage keys and single random items.
  task automatic gen_phase(input int n, input bit leave_open);
    int stop_at;
    int pick;
    int kc;
    int slot;
    int p;
    int len;
    logic [1:0] m;
    stop_at = items_made + n;
    while (items_made < stop_at) begin
      kc = (plan_count > NUM_KEYS) ? NUM_KEYS : plan_count;
      slot = (kc > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, kc - 1) :
             $urandom_range(0, NUM_KEYS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 55) stream_key(slot, key_shape_t'($urandom_range(0, 5)));
      else if (pick < 58) stream_key(slot, KEY_OPEN);
      else if (pick < 68) load_random_key(slot);
      else if (pick < 72) copy_key(slot, $urandom_range(0, NUM_KEYS - 1));
      else if (pick < 80) begin
        repeat ($urandom_range(0, 5)) push_stream($urandom_range(0, 255));
        if ($urandom_range(0, 1)) push_end();
        else push_stream(QUOTE_CHAR);
      end else begin
        m = $urandom_range(0, 3);
        case (m)
          MODE_LOAD_CHAR:
            push_item(MODE_LOAD_CHAR, slot, $urandom_range(0, 31), $urandom_range(0, 255),
                      $urandom_range(0, 63));
          MODE_LOAD_LEN: begin
            // keep the new length inside the written prefix of the slot
            p = 0;
            while (p < MAX_KEY_LEN && plan_wr[slot][p]) p++;
            len = $urandom_range(0, 63);
            if (((len > MAX_KEY_LEN) ? MAX_KEY_LEN : len) > p) len = $urandom_range(0, p);
            push_item(MODE_LOAD_LEN, slot, $urandom_range(0, 31), $urandom_range(0, 255), len);
          end
          MODE_STREAM: push_stream($urandom_range(0, 255));
          MODE_END: push_end();
        endcase
      end
    end
    if (leave_open) stream_key($urandom_range(0, NUM_KEYS - 1), KEY_OPEN);
  endtask

  // Wait until every queued item has transferred and every report came
  // back, then give the two-stage pipe time to empty.
  task automatic wait_idle();
    do @(negedge clk); while (items_taken != items_made || match_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle.
  task automatic write_count(input int v);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    plan_count = v;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int kc_plan [8];
    int rand_start;
    int ph;
    kc_plan = '{31, 0, 16, 5, 1, 15, 31, 9};
    for (int s = 0; s < NUM_KEYS; s++) plan_wr[s] = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty table after reset: nothing can match.
    push_stream(8'h61);
    push_stream(QUOTE_CHAR);
    push_end();

    // Give every slot a length before any count exposes it.
    for (int s = 0; s < NUM_KEYS; s++)
      push_item(MODE_LOAD_LEN, s, $urandom_range(0, 31), $urandom_range(0, 255), 0);
    set_text("ab");
    put_key(0, 2, 2);
    put_key(3, 2, 2);
    set_text("a\\\"b");
    put_key(1, 4, 4);
    // full-length key with both byte extremes, loaded with an oversized length
    for (int p = 0; p < MAX_KEY_LEN; p++)
      kbuf[p] = (p == 0) ? 8'hFF : (p == 1) ? NUL_CHAR : 8'(8'h61 + p);
    put_key(15, MAX_KEY_LEN, 63);
    wait_idle();
    write_count(NUM_KEYS);

    stream_key(0, KEY_EXACT);              // hit on the lower of two duplicates
    push_stream(QUOTE_CHAR);               // empty key hits the first zero-length slot
    push_stream(8'h61);
    push_end();                            // end of text in the middle of a key
    stream_key(1, KEY_EXACT);              // escaped quote stays part of the key
    push_stream(BACKSLASH_CHAR);
    push_stream(BACKSLASH_CHAR);
    push_stream(QUOTE_CHAR);               // even backslash run: the quote closes
    stream_key(15, KEY_EXACT);             // longest key
    repeat (MAX_KEY_LEN + 2) push_stream(8'h78);
    push_stream(QUOTE_CHAR);               // count saturates, never found
    push_stream(8'h61);
    push_stream(8'h62);
    push_stream(NUL_CHAR);
    push_stream(QUOTE_CHAR);               // zero byte past the stored length
    stream_key(0, KEY_EOT);
    stream_key(0, KEY_MIXED);              // loads while a key is in flight
    wait_idle();

    // Random part: fill the rest of the table, then walk through counts,
    // the extremes among them, sometimes leaving a key open across a change.
    rand_start = items_made;
    for (int s = 4; s < 15; s++) load_random_key(s);
    ph = 0;
    while (items_made < rand_start + RANDOM_ITEMS) begin
      wait_idle();
      write_count((ph < 8) ? kc_plan[ph] : $urandom_range(0, 31));
      gen_phase(120, $urandom_range(0, 3) == 0);
      ph++;
    end
    wait_idle();

    $display("covered %0d transfers in across %0d key_count settings",
             items_taken, settings_used);
    $display("checked %0d match reports, %0d of them hits", reports, hits);
    if (errors == 0) $display("json_key_table_matcher_core test passed");
    else $display("json_key_table_matcher_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    // hold the payload until it transfers, then advance or idle
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_data <= item_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // some bursts run long with no gap at all
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) :
                       $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end

    // result side stall: switch to a random pattern once the current run is used up
    if (stall_left == 0) begin
      stall_kind = rx_pattern_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 240);
    end
    stall_left--;
    case (stall_kind)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      RX_SQUARE: out_stall <= ((stall_left / 8) % 2 == 1);
    endcase
  end

  // ---------------------------------------------------------------------
  // Monitor: sample on the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    jktm_out_t want;
    bit has_rep;
    in_took = 1'b0;
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        tbl_len[i] = '0;
        for (int j = 0; j < MAX_KEY_LEN; j++) tbl_char[i][j] = '0;
      end
      live_mask = '1;
      seen_cnt = '0;
      bs_odd = 1'b0;
      tbl_count = '0;
    end else begin
      if (cfg_we) tbl_count = cfg_wdata;

      // predict on every input transfer
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        items_taken++;
        step_matcher(in_data, has_rep, want);
        if (has_rep) match_q.push_back(want);
      end

      // check every output transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        reports++;
        if (match_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, actual found %0b key_index %0d",
                   $time, out_data.found, out_data.key_index);
        end else begin
          want = match_q.pop_front();
          if (want.found) hits++;
          if (out_data.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, out_data.found);
          end
          if (out_data.key_index !== want.key_index) begin
            errors++;
            $display("%0t: key_index mismatch, expected %0d actual %0d",
                     $time, want.key_index, out_data.key_index);
          end
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed", cycles, match_q.size());
      $display("json_key_table_matcher_core test failed");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
sv/jktm_pkg.sv
sv/jktm_char_ram.sv
sv/jktm_match.sv
sv/json_key_table_matcher_core.sv
sv/jktm_checker.sv
bench/testbench.sv
